@@ rtl/psb_pkg.sv @@
// Package for the permutable spike-train buffer: op codes, controller states,
// the command and status structs between controller and datapath, and defaults.
// No dependencies.
package psb_pkg;

   // Default sizes
   localparam int NeuronsDefault   = 64;
   localparam int TimestepsDefault = 64;

   // Transaction field widths
   localparam int OpW   = 3;
   localparam int IdW   = 6;
   localparam int UcntW = 7;

   // Op codes of a request transaction
   typedef enum logic [OpW-1:0] {
      OP_MARK  = 3'd0,
      OP_CLOSE = 3'd1,
      OP_READ  = 3'd2,
      OP_STAGE = 3'd3,
      OP_APPLY = 3'd4,
      OP_CLEAR = 3'd5,
      OP_QUERY = 3'd6
   } psb_op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK_WR,
      ST_APPLY_WR,
      ST_SCAN
   } psb_state_type;

   // Controller to datapath
   typedef struct packed {
      logic close_step;
      logic stage;
      logic clear;
      logic mark_rd;
      logic mark_wr;
      logic apply_rd;
      logic apply_wr;
      logic scan_load;
      logic scan_query;
      logic scan_run;
   } psb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
   } psb_status_type;

endpackage

@@ rtl/psb_ctrl.sv @@
// Controller of the permutable spike-train buffer: decodes request transactions
// and sequences the datapath. Depends on psb_pkg.
module psb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [psb_pkg::OpW-1:0] req_op,
   input  psb_pkg::psb_status_type status,
   output psb_pkg::psb_cmd_type    cmd
);
   import psb_pkg::*;

   psb_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (psb_op_type'(req_op))
                  OP_MARK: begin
                     cmd.mark_rd = 1'b1;
                     state_in    = ST_MARK_WR;
                  end
                  OP_CLOSE: cmd.close_step = 1'b1;
                  OP_READ: begin
                     cmd.scan_load = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  OP_STAGE: cmd.stage = 1'b1;
                  OP_APPLY: begin
                     cmd.apply_rd = 1'b1;
                     state_in     = ST_APPLY_WR;
                  end
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_QUERY: begin
                     cmd.scan_load  = 1'b1;
                     cmd.scan_query = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_APPLY_WR: begin
            cmd.apply_wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/psb_datapath.sv @@
// Datapath of the permutable spike-train buffer: spike, permutation and staging
// memories, pointers, the scan pipeline and the result register. Depends on psb_pkg.
module psb_datapath #(
   parameter int NEURONS   = psb_pkg::NeuronsDefault,
   parameter int TIMESTEPS = psb_pkg::TimestepsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  psb_pkg::psb_cmd_type      cmd,
   output psb_pkg::psb_status_type   status,
   input  logic [psb_pkg::IdW-1:0]   req_neuron,
   input  logic [psb_pkg::IdW-1:0]   req_perm_index,
   input  logic [psb_pkg::UcntW-1:0] req_unit_count,
   input  logic                      req_final_req,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [psb_pkg::IdW-1:0]   rsp_neuron_id,
   output logic                      rsp_has_neuron,
   output logic                      rsp_last
);
   import psb_pkg::*;

   localparam int NIW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int NCW = $clog2(NEURONS + 1);
   localparam int TIW = (TIMESTEPS > 1) ? $clog2(TIMESTEPS) : 1;
   localparam int TCW = $clog2(TIMESTEPS + 1);
   localparam logic [UcntW-1:0] NeuronsU = UcntW'(NEURONS);
   localparam logic [NCW-1:0]   NeuronsC = NCW'(NEURONS);
   localparam logic [TCW-1:0]   StepsC   = TCW'(TIMESTEPS);

   // Memories: spike rows per timestep, permutation table, staged ids
   logic [NEURONS-1:0] spk_mem  [TIMESTEPS];
   logic [NIW-1:0]     perm_mem [NEURONS];
   logic [NIW-1:0]     stg_mem  [NEURONS];

   // Valid bits and per-neuron activity flags
   logic [TIMESTEPS-1:0] tvalid_ff;
   logic [NEURONS-1:0]   perm_valid_ff;
   logic [NEURONS-1:0]   active_ff;

   // Pointers and staging counters
   logic [TCW-1:0] write_step_ff;
   logic [TCW-1:0] read_step_ff;
   logic [NCW-1:0] stage_count_ff;
   logic [NCW-1:0] apply_count_ff;

   // Captured request state
   logic           mark_ok_ff;
   logic [NIW-1:0] mark_idx_ff;
   logic           apply_ok_ff;
   logic           apply_final_ff;

   // Memory read registers
   logic [NEURONS-1:0] spk_q_ff;
   logic               spk_vq_ff;
   logic [NIW-1:0]     perm_q_ff;
   logic               perm_vq_ff;
   logic [NIW-1:0]     stg_a_q_ff;
   logic [NIW-1:0]     stg_b_q_ff;

   // Scan pipeline
   logic [NCW-1:0] idx_ff;
   logic [NCW-1:0] limit_ff;
   logic           query_ff;
   logic           b_valid_ff;
   logic [NIW-1:0] b_idx_ff;
   logic           pend_valid_ff;
   logic [NIW-1:0] pend_id_ff;

   // Result register
   logic           rsp_valid_ff;
   logic [NIW-1:0] rsp_id_ff;
   logic           rsp_has_ff;
   logic           rsp_last_ff;

   logic               neuron_ok;
   logic               can_write;
   logic               can_read;
   logic               stage_ok;
   logic               apply_ok;
   logic [TIW-1:0]     spk_addr;
   logic [NEURONS-1:0] row;
   logic [NEURONS-1:0] mark_row;
   logic [NIW-1:0]     cand;
   logic               adv;
   logic               a_go;
   logic               hit;
   logic               push;
   logic               fin;

   // Request checks
   always_comb begin
      neuron_ok = ({1'b0, req_neuron} < NeuronsU);
      can_write = (write_step_ff < StepsC);
      can_read  = (read_step_ff < write_step_ff);
      stage_ok  = neuron_ok && (stage_count_ff < NeuronsC);
      apply_ok  = (apply_count_ff < stage_count_ff) &&
                  ({1'b0, req_perm_index} < UcntW'(stage_count_ff));
      spk_addr  = cmd.mark_rd ? write_step_ff[TIW-1:0] : read_step_ff[TIW-1:0];
   end

   // Scan step: stage B checks the candidate, stage A reads the table
   always_comb begin
      row      = spk_vq_ff ? spk_q_ff : '0;
      mark_row = row | (NEURONS'(1) << mark_idx_ff);
      adv      = cmd.scan_run && (!rsp_valid_ff || !rsp_stall);
      a_go     = (idx_ff < limit_ff);
      cand     = (query_ff || !perm_vq_ff) ? b_idx_ff : perm_q_ff;
      hit      = b_valid_ff && (query_ff ? active_ff[b_idx_ff] : row[cand]);
      push     = adv && hit && pend_valid_ff;
      fin      = adv && !a_go && !b_valid_ff;
      status.scan_done = fin;
   end

   // Memory writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.mark_rd || cmd.scan_load) begin
         spk_q_ff  <= spk_mem[spk_addr];
         spk_vq_ff <= tvalid_ff[spk_addr];
      end
      if (cmd.mark_wr && mark_ok_ff) begin
         spk_mem[write_step_ff[TIW-1:0]] <= mark_row;
      end
      if (adv && a_go) begin
         perm_q_ff  <= perm_mem[idx_ff[NIW-1:0]];
         perm_vq_ff <= perm_valid_ff[idx_ff[NIW-1:0]];
      end
      if (cmd.apply_wr && apply_ok_ff) begin
         perm_mem[stg_a_q_ff] <= stg_b_q_ff;
      end
      if (cmd.stage && stage_ok) begin
         stg_mem[stage_count_ff[NIW-1:0]] <= req_neuron[NIW-1:0];
      end
      if (cmd.apply_rd) begin
         stg_a_q_ff <= stg_mem[apply_count_ff[NIW-1:0]];
         stg_b_q_ff <= stg_mem[req_perm_index[NIW-1:0]];
      end
   end

   // Captured request fields
   always_ff @(posedge clock) begin
      if (cmd.mark_rd) begin
         mark_ok_ff  <= can_write && neuron_ok;
         mark_idx_ff <= req_neuron[NIW-1:0];
      end
      if (cmd.apply_rd) begin
         apply_ok_ff    <= apply_ok;
         apply_final_ff <= req_final_req;
      end
   end

   // Pointers, counters and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff      <= '0;
         perm_valid_ff  <= '0;
         active_ff      <= '0;
         write_step_ff  <= '0;
         read_step_ff   <= '0;
         stage_count_ff <= '0;
         apply_count_ff <= '0;
      end else begin
         if (cmd.clear) begin
            tvalid_ff     <= '0;
            perm_valid_ff <= '0;
            active_ff     <= '0;
            write_step_ff <= '0;
            read_step_ff  <= '0;
         end
         if (cmd.close_step && can_write) begin
            write_step_ff <= write_step_ff + TCW'(1);
         end
         if (cmd.mark_wr && mark_ok_ff) begin
            tvalid_ff[write_step_ff[TIW-1:0]] <= 1'b1;
            active_ff[mark_idx_ff]            <= 1'b1;
         end
         if (cmd.scan_load && !cmd.scan_query && can_read) begin
            read_step_ff <= read_step_ff + TCW'(1);
         end
         if (cmd.stage && stage_ok) begin
            stage_count_ff <= stage_count_ff + NCW'(1);
         end
         if (cmd.apply_wr) begin
            if (apply_ok_ff) begin
               perm_valid_ff[stg_a_q_ff] <= 1'b1;
            end
            if (apply_final_ff) begin
               stage_count_ff <= '0;
               apply_count_ff <= '0;
            end else if (apply_ok_ff) begin
               apply_count_ff <= apply_count_ff + NCW'(1);
            end
         end
      end
   end

   // Scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         limit_ff      <= '0;
         query_ff      <= 1'b0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (cmd.scan_load) begin
         idx_ff        <= '0;
         query_ff      <= cmd.scan_query;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         if (cmd.scan_query) begin
            limit_ff <= (req_unit_count > NeuronsU) ? NeuronsC : NCW'(req_unit_count);
         end else begin
            limit_ff <= can_read ? NeuronsC : '0;
         end
      end else if (adv) begin
         b_valid_ff <= a_go;
         if (a_go) begin
            idx_ff <= idx_ff + NCW'(1);
         end
         if (hit) begin
            pend_valid_ff <= 1'b1;
         end else if (fin) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Scan payload: candidate index and held hit
   always_ff @(posedge clock) begin
      if (adv && a_go) begin
         b_idx_ff <= idx_ff[NIW-1:0];
      end
      if (adv && hit) begin
         pend_id_ff <= cand;
      end
   end

   // Result register: a hit is sent once the next one is known, the final one last
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push || fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_id_ff   <= pend_id_ff;
         rsp_has_ff  <= 1'b1;
         rsp_last_ff <= 1'b0;
      end else if (fin) begin
         rsp_id_ff   <= pend_valid_ff ? pend_id_ff : '0;
         rsp_has_ff  <= pend_valid_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_id  = IdW'(rsp_id_ff);
   assign rsp_has_neuron = rsp_has_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ rtl/permutable_spike_train_buffer_unit.sv @@
// Top level of the permutable spike-train buffer: controller plus datapath.
// Depends on psb_pkg, psb_ctrl and psb_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  op, neuron, perm_index, unit_count, final_req
//   rsp_      out        rsp_valid / rsp_stall  neuron_id, has_neuron, last
//
// Close, stage and clear act in the idle state; mark and apply read memory, then write.
// Read and query scan one candidate per cycle through the permutation table read port
// while the result register is not stalled, up to NEURONS or the clamped unit count.
// One transaction is in progress at a time; req_stall is high until it finishes.
// A stalled result register holds the scan. Reset is synchronous and clears the
// pointers, counters and valid bits at once, so no clearing pass is needed.
module permutable_spike_train_buffer_unit #(
   parameter int NEURONS   = psb_pkg::NeuronsDefault,
   parameter int TIMESTEPS = psb_pkg::TimestepsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [psb_pkg::OpW-1:0]   req_op,
   input  logic [psb_pkg::IdW-1:0]   req_neuron,
   input  logic [psb_pkg::IdW-1:0]   req_perm_index,
   input  logic [psb_pkg::UcntW-1:0] req_unit_count,
   input  logic                      req_final_req,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [psb_pkg::IdW-1:0]   rsp_neuron_id,
   output logic                      rsp_has_neuron,
   output logic                      rsp_last
);
   import psb_pkg::*;

   psb_cmd_type    cmd;
   psb_status_type status;

   // Sequencer
   psb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and scan
   psb_datapath #(
      .NEURONS   (NEURONS),
      .TIMESTEPS (TIMESTEPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_neuron     (req_neuron),
      .req_perm_index (req_perm_index),
      .req_unit_count (req_unit_count),
      .req_final_req  (req_final_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_neuron_id  (rsp_neuron_id),
      .rsp_has_neuron (rsp_has_neuron),
      .rsp_last       (rsp_last)
   );

   // A read or query always goes on to scan
   a_load_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_load |=> cmd.scan_run)
      else $error("scan did not start after load");

   // Scan completion only while scanning
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.scan_done |-> cmd.scan_run)
      else $error("scan done outside scan");

   // A mark read is followed by its write
   a_mark_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_rd |=> cmd.mark_wr)
      else $error("mark write missing");

   // When idle, only the final result of a transaction may still wait
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (!req_stall && rsp_valid) |-> rsp_last)
      else $error("non-final result pending while idle");

endmodule
